>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the nozzle range mapper checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset holds
`define NRM_ASSERT(lbl, clk, rst, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, always on
`define NRM_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/nrm_pkg.sv
// ---------------------------------------------------------------------------
// nrm_pkg
// Widths, reset values, register map and control types of the mapper.
// ---------------------------------------------------------------------------
package nrm_pkg;

    localparam int MAX_NOZZLES_DEF = 64;
    localparam int PIXEL_BITS_DEF  = 16;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int XW      = 17;
    localparam int CW      = 15;
    localparam int PPN_W   = 16;
    localparam int CNT_W   = 7;
    localparam int FID_W   = 12;
    localparam int ID_W    = 13;
    localparam int FRAC_W  = 8;
    localparam int DIVQ_W  = CW + FRAC_W;
    localparam int ACC_W   = 23;
    localparam int LB_W    = ACC_W + 1 - FRAC_W;
    localparam int DCNT_W  = $clog2(DIVQ_W + 1);

    localparam logic [CW-1:0]    FW_RST  = 15'd1024;
    localparam logic [CW-1:0]    LP_RST  = 15'd0;
    localparam logic [CW-1:0]    RP_RST  = 15'd0;
    localparam logic [PPN_W-1:0] PPN_RST = 16'd4096;
    localparam logic [CNT_W-1:0] NC_RST  = 7'd64;
    localparam logic [FID_W-1:0] FID_RST = 12'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_LEFT_PAD     = 3'd1,
        REG_RIGHT_PAD    = 3'd2,
        REG_PIX_PER_NOZ  = 3'd3,
        REG_NOZZLE_COUNT = 3'd4,
        REG_FIRST_ID     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEL_X0   = 2'd0,
        SEL_X1   = 2'd1,
        SEL_FROM = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     save_n0;
        logic     save_n1;
        logic     init_range;
        logic     init_scan;
        logic     gen_step;
        logic     flush;
    } nrm_cmd_t;

    typedef struct packed {
        logic span_empty;
        logic pre0;
        logic pre1;
        logic any_end;
        logic scan_none;
        logic div_done;
        logic q_ok;
        logic gen_done;
        logic out_free;
    } nrm_stat_t;

endpackage

>>> rtl/nrm_div.sv
// ---------------------------------------------------------------------------
// nrm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module nrm_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [nrm_pkg::DIVQ_W-1:0] num,
    input  logic [nrm_pkg::PPN_W-1:0]  den,
    output logic                       done,
    output logic [nrm_pkg::DIVQ_W-1:0] quo,
    output logic [nrm_pkg::PPN_W-1:0]  rem
);
    import nrm_pkg::*;

    logic [DIVQ_W-1:0] sh_reg, sh_next;
    logic [PPN_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [PPN_W:0]    trial;
    logic [PPN_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, sh_reg[DIVQ_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_comb begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cnt_reg != '0) begin
            sh_next   = {sh_reg[DIVQ_W-2:0], ge};
            rem_next  = ge ? diff[PPN_W-1:0] : trial[PPN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DCNT_W'(1));
        end else if (start) begin
            sh_next  = num;
            rem_next = '0;
            cnt_next = DCNT_W'(DIVQ_W);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = sh_reg;
    assign rem  = rem_reg;

endmodule

>>> rtl/nrm_datapath.sv
// ---------------------------------------------------------------------------
// nrm_datapath
// Config registers, span tests, nozzle walker and result register.
// ---------------------------------------------------------------------------
module nrm_datapath #(
    parameter int MAX_NOZZLES = nrm_pkg::MAX_NOZZLES_DEF,
    parameter int PIXEL_BITS  = nrm_pkg::PIXEL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nrm_pkg::nrm_cmd_t             cmd,
    output nrm_pkg::nrm_stat_t            stat,
    input  logic [nrm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          cfg_valid,
    input  logic [nrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nrm_pkg::CFG_DAT_W-1:0] cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nrm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [nrm_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import nrm_pkg::*;

    logic [CW-1:0]    fw_reg, lp_reg, rp_reg;
    logic [PPN_W-1:0] ppn_reg;
    logic [CNT_W-1:0] nc_reg;
    logic [FID_W-1:0] fid_reg;

    logic signed [XW-1:0] x0_reg, x1_reg;
    logic                 v0_reg, v1_reg;
    logic [CNT_W-1:0]     n0_reg, n1_reg;

    logic              scan_reg;
    logic [CNT_W-1:0]  k_reg, hi_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [LB_W-1:0]   t_reg;
    logic              pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]   pend_id_reg;

    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_id_reg;
    logic              m_empty_reg, m_last_reg;

    logic signed [XW-1:0] fw_s, as_s, ae_s, x1m, from_s, to_s, fd, d_sel;
    logic [CNT_W-1:0]     cnt_eff;
    logic [DIVQ_W-1:0]    div_num, div_q;
    logic [PPN_W-1:0]     div_rem;
    logic                 div_done, q_ok;
    logic [ACC_W:0]       acc_init, lo_sum, hi_sum;
    logic [LB_W-1:0]      lo_b, hi_b;
    logic                 gen_done, gen_hit, out_free;
    logic [ID_W-1:0]      k_id;
    logic                 push;
    logic [ID_W-1:0]      push_id;
    logic                 push_empty, push_last;

    function automatic logic pix_ok(input logic signed [XW-1:0] x,
                                    input logic signed [XW-1:0] fw,
                                    input logic signed [XW-1:0] as,
                                    input logic signed [XW-1:0] ae,
                                    input logic [PPN_W-1:0] ppn);
        logic ok;
        ok = (x >= 0) && (x < fw) && (x >= as) && (x < ae) && (ppn != '0);
        return ok;
    endfunction

    assign fw_s   = $signed({2'b00, fw_reg});
    assign as_s   = $signed({2'b00, lp_reg});
    assign ae_s   = fw_s - $signed({2'b00, rp_reg});
    assign x1m    = x1_reg - XW'(1);
    assign from_s = (x0_reg > as_s) ? x0_reg : as_s;
    assign to_s   = (x1_reg < ae_s) ? x1_reg : ae_s;
    assign fd     = from_s - as_s;
    assign cnt_eff = (nc_reg > CNT_W'(MAX_NOZZLES)) ? CNT_W'(MAX_NOZZLES) : nc_reg;

    always_comb begin
        unique case (cmd.div_sel)
            SEL_X0:   d_sel = x0_reg - as_s;
            SEL_X1:   d_sel = x1m - as_s;
            SEL_FROM: d_sel = fd;
            default:  d_sel = '0;
        endcase
    end
    assign div_num = {d_sel[CW-1:0], {FRAC_W{1'b0}}};

    nrm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (ppn_reg),
        .done    (div_done),
        .quo     (div_q),
        .rem     (div_rem)
    );

    assign q_ok = div_q < DIVQ_W'(cnt_eff);

    assign acc_init = {1'b0, fd[CW-1:0], {FRAC_W{1'b0}}} + (ACC_W+1)'(ppn_reg)
                    - (ACC_W+1)'(div_rem);
    assign lo_sum   = {1'b0, acc_reg} + (ACC_W+1)'((1 << FRAC_W) - 1);
    assign hi_sum   = lo_sum + (ACC_W+1)'(ppn_reg);
    assign lo_b     = lo_sum[ACC_W:FRAC_W];
    assign hi_b     = hi_sum[ACC_W:FRAC_W];
    assign k_id     = ID_W'(fid_reg) + ID_W'(k_reg);

    assign gen_done = scan_reg ? ((lo_b >= t_reg) || (k_reg >= cnt_eff)) : (k_reg > hi_reg);
    assign gen_hit  = scan_reg ? (lo_b < hi_b) : 1'b1;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        push       = 1'b0;
        push_id    = pend_id_reg;
        push_empty = 1'b0;
        push_last  = 1'b0;
        pend_valid_next = pend_valid_reg;
        if (cmd.load) begin
            pend_valid_next = 1'b0;
        end else if (cmd.init_scan) begin
            pend_valid_next = 1'b1;
        end else if (cmd.gen_step && !gen_done && gen_hit) begin
            push            = pend_valid_reg;
            pend_valid_next = 1'b1;
        end else if (cmd.flush) begin
            push            = 1'b1;
            push_id         = pend_valid_reg ? pend_id_reg : '0;
            push_empty      = !pend_valid_reg;
            push_last       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= FW_RST;
            lp_reg  <= LP_RST;
            rp_reg  <= RP_RST;
            ppn_reg <= PPN_RST;
            nc_reg  <= NC_RST;
            fid_reg <= FID_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  fw_reg  <= cfg_data[CW-1:0];
                REG_LEFT_PAD:     lp_reg  <= cfg_data[CW-1:0];
                REG_RIGHT_PAD:    rp_reg  <= cfg_data[CW-1:0];
                REG_PIX_PER_NOZ:  ppn_reg <= cfg_data[PPN_W-1:0];
                REG_NOZZLE_COUNT: nc_reg  <= cfg_data[CNT_W-1:0];
                REG_FIRST_ID:     fid_reg <= cfg_data[FID_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            scan_reg       <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cmd.load) begin
                v0_reg <= 1'b0;
                v1_reg <= 1'b0;
            end
            if (cmd.save_n0) begin
                v0_reg <= q_ok;
            end
            if (cmd.save_n1) begin
                v1_reg <= q_ok;
            end
            if (cmd.init_range) begin
                scan_reg <= 1'b0;
            end
            if (cmd.init_scan) begin
                scan_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg <= XW'($signed(s_tdata[PIXEL_BITS-1:0]));
            x1_reg <= XW'($signed(s_tdata[S_TDATA_W/2 +: PIXEL_BITS]));
        end
        if (cmd.save_n0) begin
            n0_reg <= div_q[CNT_W-1:0];
        end
        if (cmd.save_n1) begin
            n1_reg <= div_q[CNT_W-1:0];
        end
        if (cmd.init_range) begin
            k_reg  <= v0_reg ? n0_reg : n1_reg;
            hi_reg <= v1_reg ? n1_reg : n0_reg;
        end else if (cmd.init_scan) begin
            pend_id_reg <= ID_W'(fid_reg) + ID_W'(div_q[CNT_W-1:0]);
            k_reg       <= div_q[CNT_W-1:0] + 1'b1;
            acc_reg     <= acc_init[ACC_W-1:0];
            t_reg       <= LB_W'(to_s - as_s);
        end else if (cmd.gen_step && !gen_done) begin
            if (gen_hit) begin
                pend_id_reg <= k_id;
            end
            k_reg   <= k_reg + 1'b1;
            acc_reg <= acc_reg + ACC_W'(ppn_reg);
        end
        if (push) begin
            m_id_reg    <= push_id;
            m_empty_reg <= push_empty;
            m_last_reg  <= push_last;
        end
    end

    assign stat.span_empty = !(x1_reg > x0_reg);
    assign stat.pre0       = pix_ok(x0_reg, fw_s, as_s, ae_s, ppn_reg);
    assign stat.pre1       = pix_ok(x1m, fw_s, as_s, ae_s, ppn_reg);
    assign stat.any_end    = v0_reg || v1_reg;
    assign stat.scan_none  = (from_s >= to_s) || (ppn_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.q_ok       = q_ok;
    assign stat.gen_done   = gen_done;
    assign stat.out_free   = out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_id_reg);
    assign m_tuser  = m_empty_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/nrm_ctrl.sv
// ---------------------------------------------------------------------------
// nrm_ctrl
// Sequencer: end pixel tests, divides, walk and final transfer.
// ---------------------------------------------------------------------------
module nrm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  nrm_pkg::nrm_stat_t stat,
    output nrm_pkg::nrm_cmd_t  cmd
);
    import nrm_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_END0  = 9'b000000010,
        ST_WAIT0 = 9'b000000100,
        ST_END1  = 9'b000001000,
        ST_WAIT1 = 9'b000010000,
        ST_PICK  = 9'b000100000,
        ST_WAITF = 9'b001000000,
        ST_GEN   = 9'b010000000,
        ST_FLUSH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = SEL_X0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_END0;
                end
            end
            ST_END0: begin
                if (stat.span_empty) begin
                    state_next = ST_FLUSH;
                end else if (stat.pre0) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = SEL_X0;
                    state_next    = ST_WAIT0;
                end else begin
                    state_next = ST_END1;
                end
            end
            ST_WAIT0: begin
                if (stat.div_done) begin
                    cmd.save_n0 = 1'b1;
                    state_next  = ST_END1;
                end
            end
            ST_END1: begin
                if (stat.pre1) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = SEL_X1;
                    state_next    = ST_WAIT1;
                end else begin
                    state_next = ST_PICK;
                end
            end
            ST_WAIT1: begin
                if (stat.div_done) begin
                    cmd.save_n1 = 1'b1;
                    state_next  = ST_PICK;
                end
            end
            ST_PICK: begin
                cmd.div_sel = SEL_FROM;
                if (stat.any_end) begin
                    cmd.init_range = 1'b1;
                    state_next     = ST_GEN;
                end else if (stat.scan_none) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_WAITF;
                end
            end
            ST_WAITF: begin
                cmd.div_sel = SEL_FROM;
                if (stat.div_done) begin
                    if (stat.q_ok) begin
                        cmd.init_scan = 1'b1;
                        state_next    = ST_GEN;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_GEN: begin
                if (stat.gen_done) begin
                    state_next = ST_FLUSH;
                end else if (stat.out_free) begin
                    cmd.gen_step = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

>>> rtl/nozzle_range_mapper_unit.sv
// ---------------------------------------------------------------------------
// nozzle_range_mapper_unit
// Maps a detector pixel span to the ejector nozzle ids it covers.
// ---------------------------------------------------------------------------
// Input stream s_*: one transfer carries a span, start pixel in the low half
// and end pixel (exclusive) in the high half. Output stream m_*: one transfer
// per nozzle id, tlast on the final one; an empty span gives one transfer
// with tuser set and id zero. The cfg_* channel writes the six mapping
// registers by index and is always ready; write it only while idle.
// One span at a time: s_tready is high only while the sequencer is idle.
// Each mapped end pixel costs one pass of the shared restoring divider; when
// neither end maps, a further pass finds the first nozzle. Ids then leave
// at up to one per cycle from the nozzle walker while the receiver takes
// them, and a final transfer closes the run.
// A stalled receiver holds the result register and pauses the walker; a new
// span is accepted while the previous last result still waits to leave.
// Reset (aresetn low at a clock edge) restores the register defaults,
// drops any span in progress and clears m_tvalid.
// ---------------------------------------------------------------------------
module nozzle_range_mapper_unit #(
    parameter int MAX_NOZZLES = nrm_pkg::MAX_NOZZLES_DEF,
    parameter int PIXEL_BITS  = nrm_pkg::PIXEL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nrm_pkg::S_TDATA_W-1:0] s_tdata,   // span_start, span_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nrm_pkg::M_TDATA_W-1:0] m_tdata,   // nozzle_id, zero pad
    output logic [nrm_pkg::M_TUSER_W-1:0] m_tuser,   // empty_res
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [nrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nrm_pkg::CFG_DAT_W-1:0] cfg_data
);
    import nrm_pkg::*;

    nrm_cmd_t  cmd;
    nrm_stat_t stat;

    assign cfg_ready = 1'b1;

    nrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    nrm_datapath #(
        .MAX_NOZZLES (MAX_NOZZLES),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> rtl/nrm_checker.sv
// ---------------------------------------------------------------------------
// nrm_checker
// Port-level checks on the mapper, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nrm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [nrm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [nrm_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import nrm_pkg::*;

    `NRM_ASSERT(a_busy_after_take, aclk, !aresetn, (s_tvalid && s_tready) |=> !s_tready, "span taken while busy")

    `NRM_ASSERT(a_hold_stalled, aclk, !aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled result changed")

    `NRM_ASSERT(a_empty_form, aclk, !aresetn, (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == '0)), "empty result malformed")

    `NRM_ASSERT_NR(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind nozzle_range_mapper_unit nrm_checker u_nrm_checker (.*);

>>> tb/nozzle_range_mapper_unit_test.sv
// ---------------------------------------------------------------------------
// nozzle_range_mapper_unit_test
// Self-checking bench for the nozzle range mapper. A directed span list
// covers the field extremes and corner settings. Fixed, then randomized,
// configuration phases follow, each with a burst of mostly well-formed spans.
// Each output transfer is checked against a directed row or an in-bench
// pixel-to-nozzle model. Both stream sides stall at random except in phase 1.
// ---------------------------------------------------------------------------
module nozzle_range_mapper_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nrm_pkg::*;

    localparam int NOZZLE_LIMIT   = MAX_NOZZLES_DEF;
    localparam int ROW_COUNT      = 37;
    localparam int PHASE_COUNT    = 6;
    localparam int SPANS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [ID_W-1:0] nozzle;
        logic            is_empty;
        logic            is_tail;
    } nozzle_hit_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PREDICT,
        ROW_FIXED
    } row_kind_t;

    typedef struct {
        row_kind_t kind;
        cfg_reg_t  sel;
        int        a;
        int        b;
        int        nozzle;
        bit        is_empty;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    logic [CW-1:0]    cfg_fw  = FW_RST;
    logic [CW-1:0]    cfg_lp  = LP_RST;
    logic [CW-1:0]    cfg_rp  = RP_RST;
    logic [PPN_W-1:0] cfg_ppn = PPN_RST;
    logic [CNT_W-1:0] cfg_cnt = NC_RST;
    logic [FID_W-1:0] cfg_fid = FID_RST;

    nozzle_hit_t expected_nozzles[$];
    int          mismatch_count = 0;
    bit          steady = 1'b0;

    stim_row_t directed_rows [ROW_COUNT] = '{
        '{ROW_FIXED,   REG_FRAME_WIDTH,  5,      5,      0,  1'b1},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  10,     3,      0,  1'b1},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  0,      1,      1,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  1008,   1024,   64, 1'b0},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  -32768, 32767,  0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  -32768, -32767, 0,  1'b1},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  32766,  32767,  0,  1'b1},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  -5,     20,     2,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  1000,   2000,   63, 1'b0},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  0,      1024,   0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  32767,  -32768, 0,  1'b1},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  -1,     0,      0,  1'b1},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  17,     50,     0,  1'b0},
        '{ROW_WRITE,   REG_FIRST_ID,     0,      0,      0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  0,      1,      0,  1'b0},
        '{ROW_WRITE,   REG_PIX_PER_NOZ,  256,    0,      0,  1'b0},
        '{ROW_WRITE,   REG_NOZZLE_COUNT, 127,    0,      0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  100,    101,    0,  1'b1},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  63,     64,     63, 1'b0},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  -10,    200,    0,  1'b0},
        '{ROW_WRITE,   REG_PIX_PER_NOZ,  0,      0,      0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  0,      10,     0,  1'b1},
        '{ROW_WRITE,   REG_PIX_PER_NOZ,  128,    0,      0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  3,      4,      6,  1'b0},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  0,      4,      0,  1'b0},
        '{ROW_WRITE,   REG_FRAME_WIDTH,  100,    0,      0,  1'b0},
        '{ROW_WRITE,   REG_RIGHT_PAD,    100,    0,      0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  0,      50,     0,  1'b1},
        '{ROW_WRITE,   REG_RIGHT_PAD,    200,    0,      0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  0,      50,     0,  1'b1},
        '{ROW_WRITE,   REG_RIGHT_PAD,    0,      0,      0,  1'b0},
        '{ROW_WRITE,   REG_NOZZLE_COUNT, 0,      0,      0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  0,      50,     0,  1'b1},
        '{ROW_WRITE,   REG_NOZZLE_COUNT, 64,     0,      0,  1'b0},
        '{ROW_WRITE,   REG_LEFT_PAD,     20,     0,      0,  1'b0},
        '{ROW_FIXED,   REG_FRAME_WIDTH,  10,     30,     18, 1'b0},
        '{ROW_PREDICT, REG_FRAME_WIDTH,  0,      100,    0,  1'b0}
    };

    nozzle_range_mapper_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic bit pixel_nozzle(input int x, output logic [ID_W-1:0] nozzle);
        int act_hi;
        int idx;
        int lim;
        act_hi = int'(cfg_fw) - int'(cfg_rp);
        lim    = (int'(cfg_cnt) > NOZZLE_LIMIT) ? NOZZLE_LIMIT : int'(cfg_cnt);
        nozzle = '0;
        if (x < 0 || x >= int'(cfg_fw)) return 1'b0;
        if (x < int'(cfg_lp) || x >= act_hi) return 1'b0;
        if (cfg_ppn == '0) return 1'b0;
        idx = ((x - int'(cfg_lp)) << FRAC_W) / int'(cfg_ppn);
        if (idx >= lim) return 1'b0;
        nozzle = ID_W'(int'(cfg_fid) + idx);
        return 1'b1;
    endfunction

    function automatic void predict_nozzles(input logic [S_TDATA_W-1:0] span);
        int              x0;
        int              x1;
        int              x;
        int              k;
        int              from_x;
        int              to_x;
        logic [ID_W-1:0] n0;
        logic [ID_W-1:0] n1;
        logic [ID_W-1:0] nz;
        logic [ID_W-1:0] lo_id;
        logic [ID_W-1:0] hi_id;
        bit              v0;
        bit              v1;
        logic [ID_W-1:0] ids[$];
        nozzle_hit_t     hit;
        x0 = $signed(span[15:0]);
        x1 = $signed(span[31:16]);
        if (x1 > x0) begin
            v0 = pixel_nozzle(x0, n0);
            v1 = pixel_nozzle(x1 - 1, n1);
            if (!v0 && !v1) begin
                from_x = (x0 > int'(cfg_lp)) ? x0 : int'(cfg_lp);
                to_x   = (x1 < int'(cfg_fw) - int'(cfg_rp)) ? x1 : int'(cfg_fw) - int'(cfg_rp);
                for (x = from_x; x < to_x; x++) begin
                    if (pixel_nozzle(x, nz) && (ids.size() == 0 || ids[$] != nz)
                            && ids.size() < NOZZLE_LIMIT) begin
                        ids.insert(ids.size(), nz);
                    end
                end
            end else begin
                if (v0 && v1) begin
                    lo_id = (n0 < n1) ? n0 : n1;
                    hi_id = (n0 < n1) ? n1 : n0;
                end else begin
                    lo_id = v0 ? n0 : n1;
                    hi_id = lo_id;
                end
                for (k = int'(lo_id); k <= int'(hi_id) && ids.size() < NOZZLE_LIMIT; k++) begin
                    ids.insert(ids.size(), ID_W'(k));
                end
            end
        end
        if (ids.size() == 0) begin
            hit.nozzle   = '0;
            hit.is_empty = 1'b1;
            hit.is_tail  = 1'b1;
            expected_nozzles.insert(expected_nozzles.size(), hit);
        end else begin
            for (k = 0; k < ids.size(); k++) begin
                hit.nozzle   = ids[k];
                hit.is_empty = 1'b0;
                hit.is_tail  = (k == ids.size() - 1);
                expected_nozzles.insert(expected_nozzles.size(), hit);
            end
        end
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_span();
        int lo;
        int hi;
        int fw;
        fw = int'(cfg_fw);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                lo = int'($urandom_range(0, fw + 16)) - 8;
                hi = lo + int'($urandom_range(0, fw / 2 + 8));
            end
            6: begin
                lo = int'($urandom_range(0, fw + 16)) - 8;
                hi = lo - int'($urandom_range(0, 40));
            end
            7: begin
                lo = int'($urandom);
                hi = int'($urandom);
            end
            8: begin
                lo = -int'($urandom_range(1, 32768));
                hi = int'($urandom_range(0, fw + 8));
            end
            default: begin
                lo = int'($urandom_range(0, int'(cfg_lp)));
                hi = fw - int'(cfg_rp) + int'($urandom_range(0, 64));
            end
        endcase
        return {hi[15:0], lo[15:0]};
    endfunction

    function automatic logic [CFG_DAT_W-1:0] with_junk(input int value, input int width);
        logic [CFG_DAT_W-1:0] junk;
        logic [CFG_DAT_W-1:0] mask;
        junk = CFG_DAT_W'($urandom);
        mask = CFG_DAT_W'((1 << width) - 1);
        return (junk & ~mask) | (CFG_DAT_W'(value) & mask);
    endfunction

    // enter and leave on a falling edge
    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (sel)
            REG_FRAME_WIDTH:  cfg_fw  = value[CW-1:0];
            REG_LEFT_PAD:     cfg_lp  = value[CW-1:0];
            REG_RIGHT_PAD:    cfg_rp  = value[CW-1:0];
            REG_PIX_PER_NOZ:  cfg_ppn = value[PPN_W-1:0];
            REG_NOZZLE_COUNT: cfg_cnt = value[CNT_W-1:0];
            REG_FIRST_ID:     cfg_fid = value[FID_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // enter on a falling edge, return at the accepting rising edge
    task automatic send_span(input logic [S_TDATA_W-1:0] span);
        while (!steady && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= span;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_nozzles.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic configure_phase(input int phase);
        int fw;
        int lp;
        int rp;
        int ppn;
        int cnt;
        int fid;
        case (phase)
            0: begin
                fw = 1024; lp = 0; rp = 0; ppn = 4096; cnt = 64; fid = 1;
            end
            1: begin
                fw = 32767; lp = 0; rp = 0; ppn = 65535; cnt = 64; fid = 4095;
            end
            2: begin
                fw = 1; lp = 0; rp = 0; ppn = 256; cnt = 127; fid = 0;
            end
            default: begin
                fw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32767)
                                                 : $urandom_range(16, 2048);
                lp = $urandom_range(0, fw / 4);
                if ($urandom_range(0, 7) == 0) begin
                    rp = fw + $urandom_range(0, 100);
                    if (rp > 32767) rp = 32767;
                end else begin
                    rp = $urandom_range(0, fw / 4);
                end
                case ($urandom_range(0, 9))
                    0:       ppn = 0;
                    1:       ppn = $urandom_range(1, 255);
                    default: ppn = $urandom_range(256, 8192);
                endcase
                cnt = $urandom_range(0, 127);
                fid = $urandom_range(0, 4095);
            end
        endcase
        write_reg(REG_FRAME_WIDTH,  with_junk(fw,  CW));
        write_reg(REG_LEFT_PAD,     with_junk(lp,  CW));
        write_reg(REG_RIGHT_PAD,    with_junk(rp,  CW));
        write_reg(REG_PIX_PER_NOZ,  with_junk(ppn, PPN_W));
        write_reg(REG_NOZZLE_COUNT, with_junk(cnt, CNT_W));
        write_reg(REG_FIRST_ID,     with_junk(fid, FID_W));
    endtask

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        nozzle_hit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_nozzles.size() == 0) begin
                $display("%0t: unexpected transfer id %0d empty %0b last %0b", $time,
                         m_tdata, m_tuser[0], m_tlast);
                mismatch_count++;
            end else begin
                want = expected_nozzles.pop_front();
                if (m_tdata !== M_TDATA_W'(want.nozzle) || m_tuser[0] !== want.is_empty
                        || m_tlast !== want.is_tail) begin
                    $display("%0t: expected id %0d empty %0b last %0b, got id %0d empty %0b last %0b",
                             $time, want.nozzle, want.is_empty, want.is_tail,
                             m_tdata, m_tuser[0], m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL nozzle_range_mapper_unit");
        $finish;
    end

    initial begin
        logic [S_TDATA_W-1:0] span;
        nozzle_hit_t          hit;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(directed_rows[r].sel, CFG_DAT_W'(directed_rows[r].a));
            end else begin
                span = {directed_rows[r].b[15:0], directed_rows[r].a[15:0]};
                send_span(span);
                if (directed_rows[r].kind == ROW_FIXED) begin
                    hit.nozzle   = ID_W'(directed_rows[r].nozzle);
                    hit.is_empty = directed_rows[r].is_empty;
                    hit.is_tail  = 1'b1;
                    expected_nozzles.insert(expected_nozzles.size(), hit);
                end else begin
                    predict_nozzles(span);
                end
                @(negedge aclk);
            end
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_drained();
            configure_phase(phase);
            steady = (phase == 1);
            for (int i = 0; i < SPANS_PER_PHASE; i++) begin
                if (phase == 3 && i == 40) wait_drained();
                span = random_span();
                send_span(span);
                predict_nozzles(span);
                @(negedge aclk);
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_nozzles.size() == 0) begin
            $display("PASS nozzle_range_mapper_unit");
        end else begin
            $display("FAIL nozzle_range_mapper_unit");
        end
        $finish;
    end

endmodule

>>> nozzle_range_mapper_unit.f
+incdir+rtl
rtl/nrm_pkg.sv
rtl/nrm_div.sv
rtl/nrm_datapath.sv
rtl/nrm_ctrl.sv
rtl/nozzle_range_mapper_unit.sv
rtl/nrm_checker.sv
tb/nozzle_range_mapper_unit_test.sv
